FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers clocked on clk_i, one muted while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define LBPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// checked at every edge, reset included
`define LBPR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: sv/lbpr_pkg.sv
// ----------------------------------------------------------------------------
// lbpr_pkg
// shared constants and types of the balanced parenthesis run tracker
// ----------------------------------------------------------------------------
package lbpr_pkg;

  // longest string that is tracked, later characters are ignored
  localparam int MAX_LEN     = 1024;
  localparam int STACK_DEPTH = MAX_LEN + 1;

  // field widths of the beats
  localparam int CHAR_W = 8;
  localparam int BEST_W = 11;

  // internal widths
  localparam int POS_W   = $clog2(MAX_LEN + 1);
  localparam int TAG_W   = POS_W;
  localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);

  localparam logic [CHAR_W-1:0] OPEN_CODE = 8'h28;

  // what a stack cell does this cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_POP,
    CELL_LOAD
  } cell_op_e;

  typedef struct packed {
    cell_op_e         op;
    logic [TAG_W-1:0] load;
  } cell_cmd_t;

  // one result beat
  typedef struct packed {
    logic [BEST_W-1:0] best_length;
    logic              final_result;
    logic              too_long;
  } lbpr_res_t;

endpackage

FILE: sv/lbpr_if.sv
// ----------------------------------------------------------------------------
// lbpr_in_if / lbpr_out_if
// valid/ready channels for character beats and result beats
// ----------------------------------------------------------------------------
interface lbpr_in_if;
  import lbpr_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

interface lbpr_out_if;
  import lbpr_pkg::*;

  logic              valid;
  logic              ready;
  logic [BEST_W-1:0] best_length;
  logic              final_result;
  logic              too_long;

  modport source (output valid, output best_length, output final_result,
                  output too_long, input ready);
  modport sink   (input valid, input best_length, input final_result,
                  input too_long, output ready);
endinterface

FILE: sv/lbpr_cell.sv
// ----------------------------------------------------------------------------
// lbpr_cell
// one entry of the shifting position stack
// ----------------------------------------------------------------------------
module lbpr_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lbpr_pkg::cell_cmd_t       cmd_i,
  input  logic [lbpr_pkg::TAG_W-1:0] up_i,
  input  logic [lbpr_pkg::TAG_W-1:0] down_i,
  output logic [lbpr_pkg::TAG_W-1:0] entry_o
);
  import lbpr_pkg::*;

  logic [TAG_W-1:0] entry_q;
  logic [TAG_W-1:0] entry_d;

  // push takes the entry above, pop the entry below
  always_comb begin
    case (cmd_i.op)
      CELL_PUSH: entry_d = up_i;
      CELL_POP:  entry_d = down_i;
      CELL_LOAD: entry_d = cmd_i.load;
      default:   entry_d = entry_q;
    endcase
  end

  // reset leaves the base marker everywhere
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

FILE: sv/lbpr_out_skid.sv
// ----------------------------------------------------------------------------
// lbpr_out_skid
// output register with a skid slot so the input side keeps flowing
// ----------------------------------------------------------------------------
module lbpr_out_skid (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lbpr_pkg::lbpr_res_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lbpr_pkg::lbpr_res_t out_data_o
);
  import lbpr_pkg::*;

  logic      out_valid_q;
  logic      skid_valid_q;
  lbpr_res_t out_data_q;
  lbpr_res_t skid_data_q;
  logic      in_fire;
  logic      out_fire;

  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && !skid_valid_q;
  assign out_fire   = out_valid_q && out_ready_i;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_valid_q && !out_fire) begin
        skid_valid_q <= 1'b1;
      end
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_data_q <= skid_data_q;
      end
    end else if (in_fire) begin
      if (!out_valid_q || out_fire) begin
        out_data_q <= in_data_i;
      end else begin
        skid_data_q <= in_data_i;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: sv/longest_balanced_paren_run.sv
// ----------------------------------------------------------------------------
// longest_balanced_paren_run
// output: each result beat is registered in the output or the skid slot
// throughput: one character per cycle unless the skid slot is full, with
//   a stack that shifts as a whole, one subtract of entry 1 and a compare
// reset: asynchronous, stack holds only the base marker, no clearing pass
// ----------------------------------------------------------------------------
module longest_balanced_paren_run (
  input  logic       clk_i,
  input  logic       rst_ni,
  lbpr_in_if.sink    in_i,
  lbpr_out_if.source out_o
);
  import lbpr_pkg::*;

  `include "assert_macros.svh"

  logic [POS_W-1:0]   pos_q, pos_d;
  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic [TAG_W-1:0]   best_q, best_d;
  logic [TAG_W-1:0]   tag;
  logic [TAG_W-1:0]   run;
  logic [TAG_W-1:0]   entry [STACK_DEPTH];
  logic               in_fire;
  logic               over;
  logic               is_open;
  logic               res_ready;
  logic               depth_ok;
  logic               last_fire;
  logic               state_clear;
  cell_cmd_t          cmd_top;
  cell_cmd_t          cmd_rest;
  lbpr_res_t          res;
  lbpr_res_t          res_out;

  assign in_fire = in_i.valid && res_ready;
  assign over    = pos_q >= POS_W'(MAX_LEN);
  assign is_open = in_i.char_code == OPEN_CODE;
  assign tag     = TAG_W'(pos_q + POS_W'(1));
  assign run     = (tag >= entry[1]) ? (tag - entry[1]) : '0;

  // per-character update of counters and stack commands
  always_comb begin
    pos_d         = pos_q;
    depth_d       = depth_q;
    best_d        = best_q;
    cmd_top.op    = CELL_HOLD;
    cmd_top.load  = tag;
    cmd_rest.op   = CELL_HOLD;
    cmd_rest.load = '0;
    if (in_fire) begin
      if (!over) begin
        pos_d = pos_q + POS_W'(1);
        if (is_open) begin
          if (depth_q < DEPTH_W'(STACK_DEPTH)) begin
            cmd_top.op  = CELL_PUSH;
            cmd_rest.op = CELL_PUSH;
            depth_d     = depth_q + DEPTH_W'(1);
          end
        end else if (depth_q <= DEPTH_W'(1)) begin
          // pop empties the stack: this position becomes the new base
          cmd_top.op = CELL_LOAD;
          depth_d    = DEPTH_W'(1);
        end else begin
          cmd_top.op  = CELL_POP;
          cmd_rest.op = CELL_POP;
          depth_d     = depth_q - DEPTH_W'(1);
          if (run > best_q) begin
            best_d = run;
          end
        end
      end
    end
  end

  // result beat carries the best after this character
  assign res.best_length  = BEST_W'(best_d);
  assign res.final_result = in_i.end_of_text;
  assign res.too_long     = over;

  // counters, cleared again after the last character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      depth_q <= DEPTH_W'(1);
      best_q  <= '0;
    end else if (in_fire && in_i.end_of_text) begin
      pos_q   <= '0;
      depth_q <= DEPTH_W'(1);
      best_q  <= '0;
    end else begin
      pos_q   <= pos_d;
      depth_q <= depth_d;
      best_q  <= best_d;
    end
  end

  // chain of stack cells, entry 0 is the top
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    cell_cmd_t        cmd;
    logic [TAG_W-1:0] up;
    logic [TAG_W-1:0] down;

    if (i == 0) begin : g_top
      always_comb begin
        cmd = cmd_top;
        if (in_fire && in_i.end_of_text) begin
          cmd.op   = CELL_LOAD;
          cmd.load = '0;
        end
      end
      assign up = tag;
    end else begin : g_rest
      always_comb begin
        cmd = cmd_rest;
        if (in_fire && in_i.end_of_text) begin
          cmd.op = CELL_HOLD;
        end
      end
      assign up = entry[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_last
      assign down = '0;
    end else begin : g_mid
      assign down = entry[i+1];
    end

    lbpr_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .up_i    (up),
      .down_i  (down),
      .entry_o (entry[i])
    );
  end

  // output register and skid slot
  lbpr_out_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (res_ready),
    .in_data_i   (res),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (res_out)
  );

  assign in_i.ready         = res_ready;
  assign out_o.best_length  = res_out.best_length;
  assign out_o.final_result = res_out.final_result;
  assign out_o.too_long     = res_out.too_long;

  // checks
  assign depth_ok    = depth_q != '0 && depth_q <= DEPTH_W'(STACK_DEPTH);
  assign last_fire   = in_fire && in_i.end_of_text;
  assign state_clear = pos_q == '0 && depth_q == DEPTH_W'(1) && best_q == '0 && entry[0] == '0;

  `LBPR_ASSERT_ALWAYS(a_depth_range, !rst_ni || depth_ok, "stack depth out of range")
  `LBPR_ASSERT(a_clear_after_last, last_fire |=> state_clear, "state not cleared after last character")
  `LBPR_ASSERT(a_best_le_pos, best_q <= TAG_W'(pos_q), "best run longer than text")
  `LBPR_ASSERT(a_stall_needs_result, !in_i.ready |-> out_o.valid, "input stalled with no result pending")

endmodule
